// ----- rtl/core/lpsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lpsp_pkg;

  // Field widths.
  localparam int unsigned StatusW  = 8;
  localparam int unsigned ProxW    = 11;
  localparam int unsigned ChW      = 16;
  localparam int unsigned LuxW     = 23;
  localparam int unsigned DiffW    = 30;
  localparam int unsigned LuxRawW  = 17;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  // Number of register stages from the input transaction to the output register.
  localparam int unsigned NumStages = 7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegLowRange = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegNearThr  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegFarThr   = CfgIdxW'(2);

  // Reset values of the configuration registers.
  localparam logic             LowRangeRst = 1'b0;
  localparam logic [ProxW-1:0] NearThrRst  = 11'h49d;
  localparam logic [ProxW-1:0] FarThrRst   = 11'h56d;

  localparam logic [ProxW-1:0]   ProxMax       = 11'h7ff;
  localparam logic [StatusW-1:0] StatusProxRdy = 8'h03;
  localparam logic [StatusW-1:0] StatusLuxRdy  = 8'h0c;

  // Lux formula coefficients.
  localparam int unsigned CoefPosLo  = 13618;
  localparam int unsigned CoefNegLo  = 15000;
  localparam int unsigned CoefPosMid = 5700;
  localparam int unsigned CoefNegMid = 3450;
  localparam int unsigned LuxDiv     = 10000;
  localparam int unsigned LowRangeDiv = 150;
  localparam int unsigned RatioLo    = 69;
  localparam int unsigned RatioScale = 100;
  localparam int unsigned LuxScale   = 50;

  typedef logic [NumStages-1:0] stage_en_t;

  typedef struct packed {
    logic             low_range;
    logic [ProxW-1:0] near_thr;
    logic [ProxW-1:0] far_thr;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             far;
    logic [ProxW-1:0] upper;
    logic [ProxW-1:0] lower;
  } prox_res_t;

  typedef struct packed {
    prox_res_t prox;
    logic      lux_valid;
  } tag_t;

endpackage

`default_nettype wire

// ----- rtl/core/lpsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lpsp_sample_if;
  logic                            valid;
  logic                            ready;
  logic [lpsp_pkg::StatusW-1:0]    status_byte;
  logic [lpsp_pkg::ProxW-1:0]      prox_count;
  logic [lpsp_pkg::ChW-1:0]        light_ch0;
  logic [lpsp_pkg::ChW-1:0]        light_ch1;

  modport source (output valid, status_byte, prox_count, light_ch0, light_ch1, input ready);
  modport sink   (input valid, status_byte, prox_count, light_ch0, light_ch1, output ready);
endinterface

interface lpsp_result_if;
  logic                         valid;
  logic                         ready;
  logic                         prox_valid;
  logic                         prox_far;
  logic [lpsp_pkg::ProxW-1:0]   window_upper;
  logic [lpsp_pkg::ProxW-1:0]   window_lower;
  logic                         lux_valid;
  logic [lpsp_pkg::LuxW-1:0]    lux_value;

  modport source (output valid, prox_valid, prox_far, window_upper, window_lower, lux_valid,
                  lux_value, input ready);
  modport sink   (input valid, prox_valid, prox_far, window_upper, window_lower, lux_valid,
                  lux_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lpsp_pipe_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lpsp_pipe_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output lpsp_pkg::stage_en_t        en_o
);

  localparam int unsigned N = lpsp_pkg::NumStages;

  logic [N-1:0] valid_q, valid_d;
  logic [N-1:0] vin;
  logic [N:0]   adv;

  // A stage may take new data when it is empty or its content moves on.
  always_comb begin
    adv[N] = out_ready_i;
    for (int i = N - 1; i >= 0; i--) begin
      adv[i] = !valid_q[i] || adv[i+1];
    end
  end

  always_comb begin
    vin = {valid_q[N-2:0], in_valid_i};
    en_o = adv[N-1:0] & vin;
    for (int i = 0; i < N; i++) begin
      valid_d[i] = adv[i] ? vin[i] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[N-1];

endmodule

`default_nettype wire

// ----- rtl/core/lpsp_prox.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lpsp_prox (
  input  wire logic                          clk_i,
  input  wire logic [lpsp_pkg::NumStages-2:0] en_i,
  input  wire logic [lpsp_pkg::StatusW-1:0]  status_i,
  input  wire logic [lpsp_pkg::ProxW-1:0]    prox_count_i,
  input  wire lpsp_pkg::cfg_t                cfg_i,
  output lpsp_pkg::tag_t                     tag_o
);

  localparam int unsigned D = lpsp_pkg::NumStages - 1;

  lpsp_pkg::tag_t tag_d;
  lpsp_pkg::tag_t tag_q [D];

  always_comb begin
    tag_d = '0;
    tag_d.lux_valid = (status_i & lpsp_pkg::StatusLuxRdy) == lpsp_pkg::StatusLuxRdy;
    if ((status_i & lpsp_pkg::StatusProxRdy) == lpsp_pkg::StatusProxRdy) begin
      if (prox_count_i >= cfg_i.near_thr) begin
        tag_d.prox.valid = 1'b1;
        tag_d.prox.far   = 1'b0;
        tag_d.prox.upper = lpsp_pkg::ProxMax;
        tag_d.prox.lower = cfg_i.far_thr;
      end else if (prox_count_i <= cfg_i.far_thr) begin
        tag_d.prox.valid = 1'b1;
        tag_d.prox.far   = 1'b1;
        tag_d.prox.upper = cfg_i.near_thr;
        tag_d.prox.lower = '0;
      end
    end
  end

  // The decision travels alongside the lux datapath until the output stage.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      tag_q[0] <= tag_d;
    end
    for (int i = 1; i < D; i++) begin
      if (en_i[i]) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  assign tag_o = tag_q[D-1];

endmodule

`default_nettype wire

// ----- rtl/core/lpsp_lux_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lpsp_lux_front (
  input  wire logic                         clk_i,
  input  wire logic [1:0]                   en_i,
  input  wire logic [lpsp_pkg::StatusW-1:0] status_i,
  input  wire logic [lpsp_pkg::ChW-1:0]     ch0_i,
  input  wire logic [lpsp_pkg::ChW-1:0]     ch1_i,
  output logic [lpsp_pkg::DiffW-1:0]        diff_o
);

  localparam int unsigned DW = lpsp_pkg::DiffW;
  localparam int unsigned RW = lpsp_pkg::ChW + 7;

  logic [RW-1:0] ch1_scaled, ch0_limit;
  logic          region_lo, region_mid, keep_d;
  logic [DW-1:0] pos_d, neg_d;
  logic [DW-1:0] pos_q, neg_q, diff_q;
  logic          keep_q;

  // The ratio floor(100*ch1/ch0) is below 69 exactly when 100*ch1 < 69*ch0,
  // and below 100 exactly when ch1 < ch0. A zero ch0 falls in neither region.
  always_comb begin
    ch1_scaled = RW'(ch1_i) * RW'(lpsp_pkg::RatioScale);
    ch0_limit  = RW'(ch0_i) * RW'(lpsp_pkg::RatioLo);
    region_lo  = ch1_scaled < ch0_limit;
    region_mid = ch1_i < ch0_i;
    keep_d     = ((status_i & lpsp_pkg::StatusLuxRdy) == lpsp_pkg::StatusLuxRdy) &&
                 (region_lo || region_mid);
    if (region_lo) begin
      pos_d = DW'(ch0_i) * DW'(lpsp_pkg::CoefPosLo);
      neg_d = DW'(ch1_i) * DW'(lpsp_pkg::CoefNegLo);
    end else begin
      pos_d = DW'(ch0_i) * DW'(lpsp_pkg::CoefPosMid);
      neg_d = DW'(ch1_i) * DW'(lpsp_pkg::CoefNegMid);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pos_q  <= pos_d;
      neg_q  <= neg_d;
      keep_q <= keep_d;
    end
    if (en_i[1]) begin
      diff_q <= (keep_q && (pos_q > neg_q)) ? (pos_q - neg_q) : '0;
    end
  end

  assign diff_o = diff_q;

endmodule

`default_nettype wire

// ----- rtl/core/lpsp_cdiv.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Two-stage division by a constant: a reciprocal multiply gives an estimate
// that is low by at most one, and the second stage corrects it.
module lpsp_cdiv #(
  parameter int unsigned DataW   = lpsp_pkg::DiffW,
  parameter int unsigned Divisor = lpsp_pkg::LuxDiv
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_a_i,
  input  wire logic             en_b_i,
  input  wire logic             bypass_i,
  input  wire logic [DataW-1:0] d_i,
  output logic [DataW-1:0]      q_o
);

  localparam longint unsigned Recip = (64'd1 << DataW) / Divisor;
  localparam int unsigned RecipW = $clog2(Recip + 1);
  localparam int unsigned ProdW  = DataW + RecipW;

  logic [ProdW-1:0]  prod;
  logic [DataW-1:0]  d_q, back, rem, q_q;
  logic [RecipW-1:0] est_q, quo;
  logic              byp_q;

  always_comb begin
    prod = ProdW'(d_i) * ProdW'(Recip);
    back = DataW'(est_q) * DataW'(Divisor);
    rem  = d_q - back;
    quo  = (rem >= DataW'(Divisor)) ? (est_q + RecipW'(1)) : est_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      d_q   <= d_i;
      est_q <= prod[ProdW-1:DataW];
      byp_q <= bypass_i;
    end
    if (en_b_i) begin
      q_q <= byp_q ? d_q : DataW'(quo);
    end
  end

  assign q_o = q_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_b_i && !byp_q) |-> ((rem - ((rem >= DataW'(Divisor)) ? DataW'(Divisor) : '0))
                            < DataW'(Divisor)))
    else $error("corrected remainder not below divisor");

endmodule

`default_nettype wire

// ----- rtl/core/light_proximity_sample_processor_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel     Dir  Handshake        Payload
// sample_i    in   valid / ready    status_byte, prox_count, light_ch0, light_ch1
// result_o    out  valid / ready    prox_valid, prox_far, window_upper, window_lower,
//                                   lux_valid, lux_value
// cfg         in   cfg_we_i only    cfg_idx_i, cfg_data_i
//
// Every sample transaction yields one result transaction. The pipeline takes one
// transaction per cycle unless a stalled output has filled every stage; its seven
// stages are two for the channel products and their difference, two for each
// constant divider (divide by 10000 and by 150) and one for the output register.
// A stalled output holds each full stage with only full stages after it; others still
// advance and fill. Reset clears stage valid bits and loads the config reset values.

module light_proximity_sample_processor_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lpsp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lpsp_pkg::CfgDataW-1:0] cfg_data_i,
  lpsp_sample_if.sink                        sample_i,
  lpsp_result_if.source                      result_o
);

  localparam int unsigned N = lpsp_pkg::NumStages;

  lpsp_pkg::cfg_t      cfg_q;
  lpsp_pkg::stage_en_t en;
  lpsp_pkg::tag_t      tag;

  logic [lpsp_pkg::DiffW-1:0]   diff;
  logic [lpsp_pkg::DiffW-1:0]   lux_div;
  logic [lpsp_pkg::LuxRawW-1:0] lux_adj;

  logic                         res_prox_valid_q, res_prox_far_q, res_lux_valid_q;
  logic [lpsp_pkg::ProxW-1:0]   res_upper_q, res_lower_q;
  logic [lpsp_pkg::LuxW-1:0]    res_lux_q;

  // Configuration writes must arrive only while the pipeline is empty (the block does
  // not check it), so every stage may read them directly. Unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_range <= lpsp_pkg::LowRangeRst;
      cfg_q.near_thr  <= lpsp_pkg::NearThrRst;
      cfg_q.far_thr   <= lpsp_pkg::FarThrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpsp_pkg::RegLowRange: cfg_q.low_range <= cfg_data_i[0];
        lpsp_pkg::RegNearThr:  cfg_q.near_thr  <= cfg_data_i[lpsp_pkg::ProxW-1:0];
        lpsp_pkg::RegFarThr:   cfg_q.far_thr   <= cfg_data_i[lpsp_pkg::ProxW-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage load enables.
  lpsp_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .en_o        (en)
  );

  // Stage 0: proximity decision, then carried along to the output stage.
  lpsp_prox u_prox (
    .clk_i        (clk_i),
    .en_i         (en[N-2:0]),
    .status_i     (sample_i.status_byte),
    .prox_count_i (sample_i.prox_count),
    .cfg_i        (cfg_q),
    .tag_o        (tag)
  );

  // Stages 0 and 1: ratio region, weighted channel products and their difference.
  lpsp_lux_front u_front (
    .clk_i    (clk_i),
    .en_i     (en[1:0]),
    .status_i (sample_i.status_byte),
    .ch0_i    (sample_i.light_ch0),
    .ch1_i    (sample_i.light_ch1),
    .diff_o   (diff)
  );

  // Stages 2 and 3: divide by 10000.
  lpsp_cdiv #(
    .DataW   (lpsp_pkg::DiffW),
    .Divisor (lpsp_pkg::LuxDiv)
  ) u_div_lux (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_a_i   (en[2]),
    .en_b_i   (en[3]),
    .bypass_i (1'b0),
    .d_i      (diff),
    .q_o      (lux_div)
  );

  // Stages 4 and 5: optional divide by 150 for the low light range.
  // The raw lux is at most 89245, so 17 bits carry it.
  lpsp_cdiv #(
    .DataW   (lpsp_pkg::LuxRawW),
    .Divisor (lpsp_pkg::LowRangeDiv)
  ) u_div_low (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_a_i   (en[4]),
    .en_b_i   (en[5]),
    .bypass_i (!cfg_q.low_range),
    .d_i      (lux_div[lpsp_pkg::LuxRawW-1:0]),
    .q_o      (lux_adj)
  );

  // Stage 6: output register with the final scale by fifty. A sample without
  // light data already carries a zero lux through the datapath.
  always_ff @(posedge clk_i) begin
    if (en[N-1]) begin
      res_prox_valid_q <= tag.prox.valid;
      res_prox_far_q   <= tag.prox.far;
      res_upper_q      <= tag.prox.upper;
      res_lower_q      <= tag.prox.lower;
      res_lux_valid_q  <= tag.lux_valid;
      res_lux_q        <= lpsp_pkg::LuxW'(lux_adj) * lpsp_pkg::LuxW'(lpsp_pkg::LuxScale);
    end
  end

  assign result_o.prox_valid   = res_prox_valid_q;
  assign result_o.prox_far     = res_prox_far_q;
  assign result_o.window_upper = res_upper_q;
  assign result_o.window_lower = res_lower_q;
  assign result_o.lux_valid    = res_lux_valid_q;
  assign result_o.lux_value    = res_lux_q;

  a_no_lux_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.lux_valid) |-> (result_o.lux_value == '0))
    else $error("lux value reported without light data");

  a_near_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.prox_valid && !result_o.prox_far) |->
    (result_o.window_upper == lpsp_pkg::ProxMax))
    else $error("near decision without full upper window");

  a_no_prox_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.prox_valid) |->
    (!result_o.prox_far && (result_o.window_upper == '0) && (result_o.window_lower == '0)))
    else $error("proximity fields set without a decision");

endmodule

`default_nettype wire
